// File: rtl/sas_pkg.sv
package sas_pkg;

  localparam int NS_W = 5;
  localparam logic [NS_W-1:0] NS_RESET = 5'd16;
  localparam int TIME_W = 32;
  localparam int IN_W = 31;
  localparam int SRV_W = 4;

  // register index taken from paddr[2]
  localparam logic REG_NUM_SERVERS = 1'b0;

  typedef enum logic [1:0] {
    S_WAIT,
    S_SCAN,
    S_HIT,
    S_MISS
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ACCEPT,
    C_FREE,
    C_EXHAUST,
    C_SLOT
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    logic  scan;
    logic  commit;
    logic  drop;
    cond_t c0;
    step_t t0;
    cond_t c1;
    step_t t1;
  } ucode_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // control store: first matching condition jumps, otherwise the step repeats
  function automatic ucode_t ucode(step_t s);
    ucode_t w;
    w = '{in_rdy: 1'b0, scan: 1'b0, commit: 1'b0, drop: 1'b0,
          c0: C_NEVER, t0: S_WAIT, c1: C_NEVER, t1: S_WAIT};
    case (s)
      S_WAIT: begin
        w.in_rdy = 1'b1;
        w.c0 = C_ACCEPT;
        w.t0 = S_SCAN;
      end
      S_SCAN: begin
        w.scan = 1'b1;
        w.c0 = C_FREE;
        w.t0 = S_HIT;
        w.c1 = C_EXHAUST;
        w.t1 = S_MISS;
      end
      S_HIT: begin
        w.commit = 1'b1;
        w.c0 = C_SLOT;
        w.t0 = S_WAIT;
      end
      S_MISS: begin
        w.drop = 1'b1;
        w.c0 = C_SLOT;
        w.t0 = S_WAIT;
      end
      default: begin
        w.c0 = C_NEVER;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/sas_in_if.sv
interface sas_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] arrival_time;
  logic [30:0] process_time;

  modport source (output valid, arrival_time, process_time, input ready);
  modport sink (input valid, arrival_time, process_time, output ready);
endinterface

// File: rtl/sas_out_if.sv
interface sas_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  assigned_server;
  logic        dropped;
  logic [31:0] server_load;

  modport source (output valid, assigned_server, dropped, server_load, input ready);
  modport sink (input valid, assigned_server, dropped, server_load, output ready);
endinterface

// File: rtl/sas_server_mem.sv
module sas_server_mem import sas_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  mem_ctl_t          ctl,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [TIME_W-1:0] wr_rel,
  input  logic [TIME_W-1:0] wr_load,
  output logic [TIME_W-1:0] rd_rel,
  output logic [TIME_W-1:0] rd_load
);

  logic [TIME_W-1:0] rel_mem [DEPTH];
  logic [TIME_W-1:0] load_mem [DEPTH];
  logic [DEPTH-1:0]  written;
  logic [TIME_W-1:0] rel_q;
  logic [TIME_W-1:0] load_q;
  logic              vld_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      rel_mem[wr_addr]  <= wr_rel;
      load_mem[wr_addr] <= wr_load;
    end
    if (ctl.rd_en) begin
      rel_q  <= rel_mem[rd_addr];
      load_q <= load_mem[rd_addr];
    end
  end

  // an entry never written reads as zero: free and unloaded
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (ctl.wr_en) written[wr_addr] <= 1'b1;
      if (ctl.rd_en) vld_q <= written[rd_addr];
    end
  end

  assign rd_rel  = vld_q ? rel_q : '0;
  assign rd_load = vld_q ? load_q : '0;

endmodule

// File: rtl/server_assignment_with_release_times.sv
// Assigns each request to one of num_servers servers. A request is taken
// only when the block is idle; the sequencer then reads the stored release
// times one server per cycle through a single read port, starting at the
// preferred server and wrapping, stopping at the first free one, or dropping
// the request when none of the servers in use is free. The next request is
// not taken until the result is registered. A result that is not taken holds
// the next one back in its commit or drop step.
// Register num_servers sits at byte address 0.
module server_assignment_with_release_times import sas_pkg::*; #(
  parameter int MAX_SERVERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  sas_in_if.sink      req,
  sas_out_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW = $clog2(MAX_SERVERS + 1);

  logic [NS_W-1:0]   num_servers;
  logic [SW-1:0]     request_slot;
  logic [IN_W-1:0]   arrive;
  logic [IN_W-1:0]   busy_for;
  logic [SW-1:0]     k;
  logic [SW-1:0]     kd;
  logic [CW-1:0]     cnt;
  logic              vld_d;
  step_t             step;
  step_t             step_next;
  ucode_t            uc;

  logic [CW-1:0]     m;
  logic [SW-1:0]     pref;
  logic [SW-1:0]     slot_next;
  logic [SW-1:0]     k_inc;
  logic              accept;
  logic              free;
  logic              issue;
  logic              exhaust;
  logic              out_slot;
  logic              c0_hit;
  logic              c1_hit;
  mem_ctl_t          mctl;
  logic [TIME_W-1:0] rd_rel;
  logic [TIME_W-1:0] rd_load;
  logic [TIME_W-1:0] load_new;
  logic [TIME_W-1:0] rel_new;

  logic              out_valid;
  logic [SRV_W-1:0]  out_srv;
  logic              out_drop;
  logic [TIME_W-1:0] out_load;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NUM_SERVERS) ? {27'b0, num_servers} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= NS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_NUM_SERVERS) begin
      num_servers <= pwdata[NS_W-1:0];
    end
  end

  // servers in use, clamped to one up to the built maximum
  always_comb begin
    if (num_servers == '0) begin
      m = CW'(1);
    end else if (32'(num_servers) > 32'(MAX_SERVERS)) begin
      m = CW'(MAX_SERVERS);
    end else begin
      m = CW'(num_servers);
    end
  end

  assign pref      = (32'(request_slot) < 32'(m)) ? request_slot : '0;
  assign slot_next = (32'(pref) + 32'd1 >= 32'(m)) ? '0 : SW'(32'(pref) + 32'd1);
  assign k_inc     = (32'(k) + 32'd1 >= 32'(m)) ? '0 : SW'(32'(k) + 32'd1);

  assign uc       = ucode(step);
  assign accept   = req.valid && req.ready;
  assign free     = vld_d && (rd_rel <= {1'b0, arrive});
  assign issue    = uc.scan && (32'(cnt) < 32'(m)) && !free;
  assign exhaust  = vld_d && !free && (32'(cnt) == 32'(m));
  assign out_slot = !out_valid || res.ready;

  assign rel_new  = {1'b0, arrive} + {1'b0, busy_for};
  assign load_new = (rd_load == '1) ? rd_load : rd_load + 32'd1;

  function automatic logic cond_true(cond_t c, logic acc, logic fr, logic ex, logic sl);
    logic r;
    case (c)
      C_NEVER:   r = 1'b0;
      C_ACCEPT:  r = acc;
      C_FREE:    r = fr;
      C_EXHAUST: r = ex;
      C_SLOT:    r = sl;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  assign c0_hit = cond_true(uc.c0, accept, free, exhaust, out_slot);
  assign c1_hit = cond_true(uc.c1, accept, free, exhaust, out_slot);

  // sequencer next step
  always_comb begin
    if (c0_hit) begin
      step_next = uc.t0;
    end else if (c1_hit) begin
      step_next = uc.t1;
    end else begin
      step_next = step;
    end
  end

  // sequencer outputs
  always_comb begin
    req.ready = uc.in_rdy;
    mctl.rd_en = issue;
    mctl.wr_en = uc.commit && out_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // scan pipeline: k is the address being read, kd the one whose data is back
  always_ff @(posedge clk) begin
    if (rst) begin
      request_slot <= '0;
      vld_d        <= 1'b0;
      cnt          <= '0;
    end else if (accept) begin
      request_slot <= slot_next;
      vld_d        <= 1'b0;
      cnt          <= '0;
    end else if (issue) begin
      vld_d <= 1'b1;
      cnt   <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arrive   <= req.arrival_time;
      busy_for <= req.process_time;
      k        <= pref;
    end else if (issue) begin
      k  <= k_inc;
      kd <= k;
    end
  end

  sas_server_mem #(
    .DEPTH (MAX_SERVERS),
    .AW    (SW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mctl),
    .rd_addr (k),
    .wr_addr (kd),
    .wr_rel  (rel_new),
    .wr_load (load_new),
    .rd_rel  (rd_rel),
    .rd_load (rd_load)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((uc.commit || uc.drop) && out_slot) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uc.commit || uc.drop) && out_slot) begin
      out_srv  <= uc.commit ? SRV_W'(kd) : '0;
      out_drop <= uc.drop;
      out_load <= uc.commit ? load_new : '0;
    end
  end

  assign res.valid           = out_valid;
  assign res.assigned_server = out_srv;
  assign res.dropped         = out_drop;
  assign res.server_load     = out_load;

endmodule

// File: rtl/sas_checker.sv
module sas_port_assert (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [3:0]  res_srv,
  input logic        res_drop,
  input logic [31:0] res_load
);

  // one request in flight: no second transaction right after the first
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_drop_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_drop |-> res_srv == 4'd0 && res_load == 32'd0)
    else $error("dropped result carries a server or load");

  a_load_counted: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_drop |-> res_load != 32'd0)
    else $error("assigned result with zero load");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_srv) && $stable(res_load))
    else $error("result changed while stalled");

endmodule

bind server_assignment_with_release_times sas_port_assert u_sas_port_assert (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_srv   (res.assigned_server),
  .res_drop  (res.dropped),
  .res_load  (res.server_load)
);

// File: sim/sas_checker.sv
module sas_checker import sas_pkg::*; #(
  parameter int MAX_SERVERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  sas_in_if           req,
  sas_out_if          res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          request_count,
  output int          drop_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SRV_W-1:0] server;
    logic             dropped;
    logic [31:0]      load;
  } assignment_t;

  logic [NS_W-1:0]   server_count_reg;
  logic [TIME_W-1:0] free_at [MAX_SERVERS];
  logic [31:0]       jobs_done [MAX_SERVERS];
  int unsigned       next_slot;
  assignment_t       awaited [$];

  initial begin
    fail_count = 0;
    pending = 0;
    request_count = 0;
    drop_count = 0;
  end

  function automatic assignment_t assign_request(logic [IN_W-1:0] arrival,
                                                 logic [IN_W-1:0] duration);
    int unsigned active;
    int unsigned first;
    int unsigned pick;
    bit          found;
    assignment_t r;
    active = server_count_reg;
    if (active == 0) active = 1;
    if (active > MAX_SERVERS) active = MAX_SERVERS;
    first = (next_slot < active) ? next_slot : 0;
    found = 1'b0;
    pick = 0;
    // scan upward from the preferred server, then wrap to the bottom
    for (int unsigned k = first; k < active && !found; k++) begin
      if (free_at[k] <= TIME_W'(arrival)) begin
        pick = k;
        found = 1'b1;
      end
    end
    for (int unsigned k = 0; k < first && !found; k++) begin
      if (free_at[k] <= TIME_W'(arrival)) begin
        pick = k;
        found = 1'b1;
      end
    end
    next_slot = (first + 1 >= active) ? 0 : first + 1;
    if (!found) begin
      r.server = '0;
      r.dropped = 1'b1;
      r.load = '0;
      return r;
    end
    free_at[pick] = TIME_W'(arrival) + TIME_W'(duration);
    if (jobs_done[pick] != '1) jobs_done[pick] = jobs_done[pick] + 1;
    r.server = SRV_W'(pick);
    r.dropped = 1'b0;
    r.load = jobs_done[pick];
    return r;
  endfunction

  always @(posedge clk) begin
    assignment_t want;
    if (rst) begin
      server_count_reg = NS_RESET;
      for (int k = 0; k < MAX_SERVERS; k++) begin
        free_at[k] = '0;
        jobs_done[k] = '0;
      end
      next_slot = 0;
      awaited.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_NUM_SERVERS) server_count_reg = pwdata[NS_W-1:0];
        end else if (paddr[2] == REG_NUM_SERVERS &&
                     prdata !== {{(32-NS_W){1'b0}}, server_count_reg}) begin
          $display("%0t: num_servers readback expected %0d got %0h", $time,
                   server_count_reg, prdata);
          fail_count++;
        end
      end
      if (res.valid && res.ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result server %0d dropped %0b load %0d", $time,
                   res.assigned_server, res.dropped, res.server_load);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (res.assigned_server !== want.server) begin
            $display("%0t: assigned_server expected %0d got %0d", $time,
                     want.server, res.assigned_server);
            fail_count++;
          end
          if (res.dropped !== want.dropped) begin
            $display("%0t: dropped expected %0b got %0b", $time,
                     want.dropped, res.dropped);
            fail_count++;
          end
          if (res.server_load !== want.load) begin
            $display("%0t: server_load expected %0d got %0d", $time,
                     want.load, res.server_load);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        want = assign_request(req.arrival_time, req.process_time);
        awaited.push_back(want);
        request_count++;
        if (want.dropped) drop_count++;
      end
    end
    pending = awaited.size();
  end

endmodule

// File: sim/tb_server_assignment_with_release_times.sv
module tb_server_assignment_with_release_times;
  timeunit 1ns;
  timeprecision 1ps;
  import sas_pkg::*;

  localparam logic REG_SPARE = 1'b1;
  localparam logic APB_READ = 1'b0;
  localparam logic APB_WRITE = 1'b1;
  localparam int LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 110;
  localparam int NS_PLAN [9] = '{2, 16, 1, 5, 31, 0, 8, 17, 3};
  localparam int PROC_PLAN [4] = '{20, 100, 400, 2000};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int request_count;
  int drop_count;
  int config_writes = 0;
  int cycles = 0;
  int stall_left = 0;
  bit steady = 1'b0;
  logic [IN_W-1:0] now_t = '0;

  sas_in_if  req_ch ();
  sas_out_if res_ch ();

  server_assignment_with_release_times uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sas_checker chk (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .res           (res_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending       (pending),
    .request_count (request_count),
    .drop_count    (drop_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
    end
  end

  // mostly forward steps, a few big jumps and the odd step back
  function automatic logic [IN_W-1:0] advance_clock(int step_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2 && now_t > 1000) now_t = now_t - IN_W'($urandom_range(1, 500));
    else if (r < 5) now_t = now_t + IN_W'($urandom_range(1 << 16, 1 << 23));
    else now_t = now_t + IN_W'($urandom_range(0, step_max));
    return now_t;
  endfunction

  function automatic logic [IN_W-1:0] pick_duration(int proc_max);
    if ($urandom_range(0, 99) < 3) return IN_W'($urandom_range(0, 1 << 24));
    return IN_W'($urandom_range(0, proc_max));
  endfunction

  task automatic send_request(input logic [IN_W-1:0] arrival,
                              input logic [IN_W-1:0] duration);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.arrival_time <= arrival;
    req_ch.process_time <= duration;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_access(input logic dir, input logic idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= dir;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // upper data bits are junk on purpose, only the low five are kept
  task automatic set_servers(input int count, input bit stray);
    logic [31:0] word;
    word = $urandom;
    word[NS_W-1:0] = NS_W'(count);
    reg_access(APB_WRITE, REG_NUM_SERVERS, word);
    if (stray) reg_access(APB_WRITE, REG_SPARE, $urandom);
    reg_access(APB_READ, REG_NUM_SERVERS, '0);
    config_writes++;
  endtask

  initial begin
    int ns;
    int step_max;
    int proc_max;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.arrival_time = '0;
    req_ch.process_time = '0;
    res_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sixteen servers from reset, one left busy almost forever
    send_request(0, 0);
    send_request(0, 31'h7FFF_FFFF);
    send_request(0, 100);
    send_request(3, 5);
    settle();
    set_servers(1, 1'b0);
    send_request(10, 50);
    send_request(20, 1);
    send_request(60, 0);
    send_request(60, 0);
    send_request(59, 5);
    settle();
    set_servers(0, 1'b0);
    send_request(61, 10);
    send_request(61, 10);
    settle();
    set_servers(31, 1'b1);
    send_request(70, 0);
    repeat (8) send_request(80, 30);
    settle();
    set_servers(17, 1'b1);
    send_request(0, 0);
    send_request(200, 0);
    now_t = 200;

    for (int phase = 0; phase < PHASES; phase++) begin
      ns = (phase < 9) ? NS_PLAN[phase] : $urandom_range(0, 31);
      settle();
      set_servers(ns, $urandom_range(0, 3) == 0);
      steady = ($urandom_range(0, 3) == 0);
      step_max = $urandom_range(0, 40);
      proc_max = PROC_PLAN[$urandom_range(0, 3)];
      repeat (PHASE_ITEMS) send_request(advance_clock(step_max), pick_duration(proc_max));
    end

    // top of the arrival range, then a step back to zero
    settle();
    steady = 1'b0;
    set_servers(16, 1'b0);
    send_request(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_request(31'h7FFF_FFFF, 0);
    send_request(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_request(0, 0);
    settle();

    $display("covered %0d requests, %0d of them dropped, across %0d server-count settings",
             request_count, drop_count, config_writes);
    $display("stray register writes and readbacks of num_servers were checked too");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
